// ===== sv/xtea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package xtea_pkg;

	localparam int unsigned WORD_W = 32;
	localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;
	localparam int unsigned KEY_SHIFT = 11;
	localparam int unsigned NUM_KEYS = 4;
	localparam int unsigned KEY_IDX_W = $clog2(NUM_KEYS);

	localparam logic ACT_ENCRYPT = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;
	typedef word_t [NUM_KEYS-1:0] key_t;

	typedef struct packed {
		logic  action;
		word_t block_left;
		word_t block_right;
		logic  last_block;
	} in_t;

	typedef struct packed {
		word_t result_left;
		word_t result_right;
		logic  result_last;
	} out_t;

	typedef struct packed {
		logic  valid;
		logic  action;
		logic  last;
		word_t v0;
		word_t v1;
	} stage_t;

	function automatic word_t mix(input word_t v);
		return ((v << 4) ^ (v >> 5)) + v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/xtea_half_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xtea_half_round (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            odd,
	input  wire xtea_pkg::word_t sum_enc,
	input  wire xtea_pkg::word_t sum_dec,
	input  wire xtea_pkg::key_t  key,
	input  wire xtea_pkg::stage_t d,
	output xtea_pkg::stage_t     q
);
	import xtea_pkg::*;

	logic     use_hi;
	word_t    sum;
	key_idx_t kidx;
	word_t    src;
	word_t    dst;
	word_t    f;
	word_t    dst_nxt;
	logic     upd_v0;
	logic     valid_s1;
	stage_t   data_s1;

	// even: enc v0 (key by low bits), dec v1 (key by high bits); odd swaps both
	always_comb begin
		sum    = (d.action == ACT_DECRYPT) ? sum_dec : sum_enc;
		use_hi = odd ^ (d.action == ACT_DECRYPT);
		kidx   = use_hi ? sum[KEY_SHIFT +: KEY_IDX_W] : sum[KEY_IDX_W-1:0];
		upd_v0 = ~use_hi;
		src    = upd_v0 ? d.v1 : d.v0;
		dst    = upd_v0 ? d.v0 : d.v1;
		f      = mix(src) ^ (sum + key[kidx]);
		dst_nxt = (d.action == ACT_DECRYPT) ? dst - f : dst + f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1.valid  <= 1'b0;
		data_s1.action <= d.action;
		data_s1.last   <= d.last;
		data_s1.v0     <= upd_v0 ? dst_nxt : d.v0;
		data_s1.v1     <= upd_v0 ? d.v1 : dst_nxt;
	end

	always_comb begin
		q       = data_s1;
		q.valid = valid_s1;
	end

endmodule
`default_nettype wire

// ===== sv/xtea_block_cipher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// XTEA block cipher core, ECB, one 64-bit block per beat.
// Input: a beat is taken when start is high and busy is low. busy is
// always low, so a new block may be presented in every cycle.
// Output: done pulses for one cycle with the transformed block on result;
// the receiver cannot stall, so results leave in input order, one per block.
// Pipeline: one register stage per XTEA half-round (64 stages at CYCLE_COUNT = 32).
// Throughput: one block per cycle.
// Key: four 32-bit words written through cfg_we / cfg_index / cfg_data;
// write only while no block is in flight.
// Reset: arst_n clears the key to zero and empties the pipeline; results
// of blocks in flight at reset are dropped.
module xtea_block_cipher_core #(
	parameter int unsigned CYCLE_COUNT = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire xtea_pkg::in_t              block_in,
	output logic                            done,
	output xtea_pkg::out_t                  result,
	input  wire logic                       cfg_we,
	input  wire logic [xtea_pkg::KEY_IDX_W-1:0] cfg_index,
	input  wire xtea_pkg::word_t            cfg_data
);
	import xtea_pkg::*;

	localparam int unsigned NUM_STAGES = 2 * CYCLE_COUNT;

	key_t   key_q;
	stage_t pipe [NUM_STAGES+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		pipe[0].valid  = start & ~busy;
		pipe[0].action = block_in.action;
		pipe[0].last   = block_in.last_block;
		pipe[0].v0     = block_in.block_left;
		pipe[0].v1     = block_in.block_right;
	end

	for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
		localparam int unsigned CYC = s / 2;
		localparam int unsigned ODD = s % 2;
		localparam longint unsigned ENC_N = CYC + ODD;
		localparam longint unsigned DEC_N = CYCLE_COUNT - CYC - ODD;
		localparam longint unsigned ENC_P = ENC_N * 64'(DELTA);
		localparam longint unsigned DEC_P = DEC_N * 64'(DELTA);
		localparam word_t SUM_E = ENC_P[WORD_W-1:0];
		localparam word_t SUM_D = DEC_P[WORD_W-1:0];

		xtea_half_round u_half (
			.clk     (clk),
			.arst_n  (arst_n),
			.odd     (ODD[0]),
			.sum_enc (SUM_E),
			.sum_dec (SUM_D),
			.key     (key_q),
			.d       (pipe[s]),
			.q       (pipe[s+1])
		);
	end

	always_comb begin
		done                = pipe[NUM_STAGES].valid;
		result.result_left  = pipe[NUM_STAGES].v0;
		result.result_right = pipe[NUM_STAGES].v1;
		result.result_last  = pipe[NUM_STAGES].last;
	end

endmodule
`default_nettype wire
